FILE: rtl/tcw_pkg.sv
// Shared constants, types and codes for the text console character writer.
package tcw_pkg;

   // Screen geometry.
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = ROWS * COLS;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(CELLS);

   // Fixed field widths of the beats.
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int POS_W   = 11;
   localparam int RADDR_W = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (POS_W + CHAR_W + ATTR_W + 1);

   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

   // Item kinds carried in tuser.
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK,
      ST_RESULT
   } tcw_state_type;

   typedef struct packed {
      logic accept_put;
      logic accept_read;
      logic clear_step;
      logic copy_step;
      logic blank_step;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic req_is_read;
      logic put_scrolls;
      logic sweep_end;
      logic copy_end;
      logic rsp_free;
   } tcw_status_type;

endpackage

FILE: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tcw_ctrl.sv
// Controller state machine: clearing pass, item handshake, scroll sweeps and result hand-off.
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);

   tcw_pkg::tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (status.sweep_end) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (!status.req_is_read && status.put_scrolls) begin
                  state_in = tcw_pkg::ST_COPY;
               end else begin
                  state_in = tcw_pkg::ST_RESULT;
               end
            end
         end
         tcw_pkg::ST_COPY: begin
            if (status.copy_end) state_in = tcw_pkg::ST_DRAIN;
         end
         tcw_pkg::ST_DRAIN: begin
            state_in = tcw_pkg::ST_BLANK;
         end
         tcw_pkg::ST_BLANK: begin
            if (status.sweep_end) state_in = tcw_pkg::ST_RESULT;
         end
         tcw_pkg::ST_RESULT: begin
            if (status.rsp_free) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         tcw_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.accept_put  = req_tvalid && !status.req_is_read;
            cmd.accept_read = req_tvalid && status.req_is_read;
         end
         tcw_pkg::ST_COPY:   cmd.copy_step  = 1'b1;
         tcw_pkg::ST_DRAIN:  cmd.copy_step  = 1'b0;
         tcw_pkg::ST_BLANK:  cmd.blank_step = 1'b1;
         tcw_pkg::ST_RESULT: cmd.load_rsp   = status.rsp_free;
         default:            cmd            = '0;
      endcase
   end

endmodule

FILE: rtl/tcw_dp.sv
// Datapath: cursor, attribute register, cell memory with its sweep counter, and result register.
module tcw_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::tcw_cmd_type           cmd,
   output tcw_pkg::tcw_status_type        status,
   input  logic                          func,
   input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
   input  logic [tcw_pkg::RADDR_W-1:0]   read_address,
   input  logic                          csr_we,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_wdata,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [tcw_pkg::POS_W-1:0]     cursor_position,
   output logic [tcw_pkg::CHAR_W-1:0]    read_char,
   output logic [tcw_pkg::ATTR_W-1:0]    read_attr,
   output logic                          scrolled
);

   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int CELL_W = tcw_pkg::CELL_W;

   logic [ROW_W-1:0]          row_ff, row_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic                      copy_wv_ff, copy_wv_in;
   logic [ADDR_W-1:0]         copy_wa_ff;
   logic                      is_read_ff, read_ok_ff, scroll_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]  rsp_pos_ff;
   logic [tcw_pkg::CHAR_W-1:0] rsp_char_ff;
   logic [tcw_pkg::ATTR_W-1:0] rsp_attr_ff;
   logic                      rsp_scroll_ff;

   logic              newline, wrap, scroll, read_in_range, rsp_free;
   logic [ROW_W-1:0]  row_w, row_n;
   logic [COL_W-1:0]  col_w, col_n;
   logic [ADDR_W-1:0] put_addr;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   // Cursor arithmetic for a put beat. The column never exceeds COLS-1, so a
   // wrap only needs an equality test, and the advanced column always fits.
   assign newline  = (char_code == tcw_pkg::CHAR_LF) || (char_code == tcw_pkg::CHAR_CR);
   assign wrap     = (col_ff == COL_W'(tcw_pkg::COLS - 1));
   assign row_w    = wrap ? row_ff + ROW_W'(1) : row_ff;
   assign col_w    = wrap ? '0 : col_ff;
   assign row_n    = newline ? row_ff + ROW_W'(1) : row_w;
   assign col_n    = newline ? '0 : col_w + COL_W'(1);
   assign scroll   = (row_n == ROW_W'(tcw_pkg::ROWS - 1));
   assign put_addr = ADDR_W'(32'(row_w) * tcw_pkg::COLS + 32'(col_w));

   assign read_in_range = 32'(read_address) < tcw_pkg::CELLS;
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.accept_put) begin
         row_in = scroll ? ROW_W'(tcw_pkg::ROWS - 2) : row_n;
         col_in = col_n;
      end
   end

   assign attr_in = csr_we ? csr_wdata : attr_ff;

   // One counter walks the memory for the clearing pass, the row copy and the
   // bottom-row blank. The copy jumps straight to the bottom row when done.
   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept_put) begin
         pos_in = ADDR_W'(tcw_pkg::COLS);
      end else if (cmd.copy_step) begin
         pos_in = status.copy_end ? ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS)
                                  : pos_ff + ADDR_W'(1);
      end else if (cmd.clear_step || cmd.blank_step) begin
         pos_in = pos_ff + ADDR_W'(1);
      end
   end

   assign copy_wv_in = cmd.copy_step;

   // The copy write comes in the cycle after its read, so it wins the write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {attr_ff, tcw_pkg::BLANK_CHAR};
      if (copy_wv_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_wa_ff;
         wr_data = rd_data;
      end else if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
      end else if (cmd.accept_put && !newline) begin
         wr_en   = 1'b1;
         wr_addr = put_addr;
         wr_data = {attr_ff, char_code};
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = pos_ff + ADDR_W'(tcw_pkg::COLS);
      if (cmd.copy_step) begin
         rd_en = 1'b1;
      end else if (cmd.accept_read && read_in_range) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(read_address);
      end
   end

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(tcw_pkg::CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= ROW_W'(1);
         col_ff       <= '0;
         attr_ff      <= tcw_pkg::RESET_ATTR;
         pos_ff       <= '0;
         copy_wv_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         pos_ff       <= pos_in;
         copy_wv_ff   <= copy_wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_wa_ff <= pos_ff;
      if (cmd.accept_put) begin
         is_read_ff <= 1'b0;
         scroll_ff  <= scroll;
      end else if (cmd.accept_read) begin
         is_read_ff <= 1'b1;
         read_ok_ff <= read_in_range;
         scroll_ff  <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_pos_ff    <= tcw_pkg::POS_W'(32'(row_ff) * tcw_pkg::COLS + 32'(col_ff));
         rsp_char_ff   <= (is_read_ff && read_ok_ff) ? rd_data[tcw_pkg::CHAR_W-1:0] : '0;
         rsp_attr_ff   <= (is_read_ff && read_ok_ff) ? rd_data[CELL_W-1:tcw_pkg::CHAR_W] : '0;
         rsp_scroll_ff <= scroll_ff;
      end
   end

   assign status.req_is_read = (func == tcw_pkg::FUNC_READ);
   assign status.put_scrolls = scroll;
   assign status.sweep_end   = (pos_ff == ADDR_W'(tcw_pkg::CELLS - 1));
   assign status.copy_end    = (pos_ff == ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS - 1));
   assign status.rsp_free    = rsp_free;

   assign rsp_valid       = rsp_valid_ff;
   assign cursor_position = rsp_pos_ff;
   assign read_char       = rsp_char_ff;
   assign read_attr       = rsp_attr_ff;
   assign scrolled        = rsp_scroll_ff;

endmodule

FILE: rtl/text_console_char_writer_unit.sv
// Top level of the text console character writer: beat packing and controller/datapath hookup.
//
// The block holds an 80 x 25 screen of character and attribute cells in one
// RAM. After reset it first runs a clearing pass (one cell per cycle) that
// fills every cell with a space in attribute 7; no request beat is taken
// during that pass, while the attribute register can be written at any
// time. A put or read beat first updates the cursor and writes or reads the
// cell, then places the result in the output register once it is free.
// A put that scrolls the screen also walks the RAM port: it copies rows two
// and up one row higher, drains the last copy write, and blanks the bottom
// row, all before its result is placed in the output register.
// One item is in work at a time; a finished result waits in the output
// register while the next request beat is taken.
module text_console_char_writer_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [7:0] char_code, [18:8] read_address, [23:19] zero
   input  logic [0:0]  req_tuser,  // [0] func
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [10:0] cursor_position, [18:11] read_char,
                                   // [26:19] read_attr, [27] scrolled, [31:28] zero
   // Attribute register write.
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   logic [tcw_pkg::POS_W-1:0]  cursor_position;
   logic [tcw_pkg::CHAR_W-1:0] read_char;
   logic [tcw_pkg::ATTR_W-1:0] read_attr;
   logic                       scrolled;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .func           (req_tuser[0]),
      .char_code      (req_tdata[7:0]),
      .read_address   (req_tdata[18:8]),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .cursor_position(cursor_position),
      .read_char      (read_char),
      .read_attr      (read_attr),
      .scrolled       (scrolled)
   );

   assign rsp_tdata = {{tcw_pkg::RSP_PAD_W{1'b0}}, scrolled, read_attr, read_char,
                       cursor_position};

endmodule
